// ===== design/bmpd_pkg.sv =====
package bmpd_pkg;

    localparam int MAX_WIDTH     = 8192;
    localparam int PALETTE_DEPTH = 256;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = 2;
    localparam int LIST_DEPTH    = 6;

    localparam logic [1:0] CMD_DATA    = 2'd0;
    localparam logic [1:0] CMD_PALETTE = 2'd1;
    localparam logic [1:0] CMD_START   = 2'd2;

    localparam logic [1:0] KIND_RUN = 2'd0;
    localparam logic [1:0] KIND_EOL = 2'd1;
    localparam logic [1:0] KIND_EOI = 2'd2;

    localparam logic [1:0] REG_DEPTH  = 2'd0;
    localparam logic [1:0] REG_RLE    = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    localparam logic [1:0] DEPTH_1 = 2'd0;
    localparam logic [1:0] DEPTH_4 = 2'd1;

    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOI   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    // one unit of back-end work: a palette write or one result
    typedef struct packed {
        logic        pal_wr;
        logic [1:0]  kind;
        logic [12:0] column;
        logic [12:0] row;
        logic [7:0]  run_length;
        logic [7:0]  idx_a;
        logic [7:0]  idx_b;
        logic [23:0] rgb;
        logic        last;
    } t_desc;

endpackage

// ===== design/bmpd_front.sv =====
module bmpd_front
    import bmpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [13:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_palette_index,
    input  logic [23:0] i_palette_rgb,
    input  logic        i_final_byte,
    output logic        o_push,
    output t_desc       o_desc,
    input  logic        i_q_full
);

    typedef enum logic [2:0] {
        PH_COUNT, PH_VALUE, PH_ESCAPE, PH_DX, PH_DY, PH_ABS, PH_DONE
    } t_phase;

    logic [1:0]  r_depth;
    logic        r_rle;
    logic [13:0] r_width, r_height;

    t_phase      r_phase, n_phase;
    logic [13:0] r_col, n_col, r_row, n_row;
    logic [7:0]  r_held, n_held, r_abs, n_abs;
    logic        r_par, n_par;
    logic [12:0] r_rbc, n_rbc;

    t_desc       r_list [LIST_DEPTH];
    t_desc       n_list [LIST_DEPTH];
    logic [2:0]  r_left, r_ptr, n_cnt;

    logic [13:0] w, h;
    logic        accept;

    always_comb begin
        w = (r_width == 14'd0) ? 14'd1 :
            (r_width > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : r_width;
        h = (r_height == 14'd0) ? 14'd1 :
            (r_height > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : r_height;
    end

    assign o_push  = (r_left != 3'd0) && !i_q_full;
    assign o_desc  = r_list[r_ptr];
    assign o_stall = (r_left > 3'd1) || ((r_left == 3'd1) && i_q_full);
    assign accept  = i_valid && !o_stall;

    function automatic t_desc mk(input logic [1:0] kind, input logic [13:0] col,
                                 input logic [13:0] row, input logic [7:0] len,
                                 input logic [7:0] ia, input logic [7:0] ib);
        t_desc d;
        d            = '0;
        d.kind       = kind;
        d.column     = col[12:0];
        d.row        = row[12:0];
        d.run_length = len;
        d.idx_a      = ia;
        d.idx_b      = (len == 8'd1) ? ia : ib;
        return d;
    endfunction

    always_comb begin
        logic [2:0]  k;
        logic        rle, four, odd;
        logic [16:0] wbits, per_row, col0, c, rem;
        logic [13:0] rbc1, len14;
        logic [14:0] sum;
        logic [7:0]  n, ia, ib, b;
        logic        do_run;

        k       = '0;
        n_phase = r_phase;
        n_col   = r_col;
        n_row   = r_row;
        n_held  = r_held;
        n_abs   = r_abs;
        n_par   = r_par;
        n_rbc   = r_rbc;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            n_list[i] = '0;
        end
        b      = i_data_byte;
        rle    = r_rle && (r_depth != DEPTH_1);
        four   = (r_depth == DEPTH_4);
        odd    = r_par;
        do_run = 1'b0;
        n      = '0;
        ia     = '0;
        ib     = '0;
        wbits  = '0;
        per_row = '0;
        col0   = '0;
        c      = '0;
        rem    = '0;
        rbc1   = '0;
        len14  = '0;
        sum    = '0;

        case (i_cmd)
            CMD_PALETTE: begin
                n_list[0].pal_wr = 1'b1;
                n_list[0].idx_a  = i_palette_index;
                n_list[0].rgb    = i_palette_rgb;
                k = 3'd1;
            end
            CMD_START: begin
                n_phase = PH_COUNT;
                n_col   = '0;
                n_row   = '0;
                n_held  = '0;
                n_abs   = '0;
                n_par   = 1'b0;
                n_rbc   = '0;
            end
            CMD_DATA: begin
                if (r_phase != PH_DONE) begin
                    if (!rle) begin
                        // uncompressed byte: up to four runs of one or two pixels
                        case (r_depth)
                            DEPTH_1: begin
                                wbits = 17'(w);
                                col0  = 17'({r_rbc, 3'b000});
                            end
                            DEPTH_4: begin
                                wbits = 17'({w, 2'b00});
                                col0  = 17'({r_rbc, 1'b0});
                            end
                            default: begin
                                wbits = 17'({w, 3'b000});
                                col0  = 17'(r_rbc);
                            end
                        endcase
                        per_row = ((wbits + 17'd31) >> 5) << 2;
                        for (int p = 0; p < 8; p += 2) begin
                            c = col0 + 17'(p);
                            if (c < 17'(w)) begin
                                rem = 17'(w) - c;
                                if (r_depth == DEPTH_1) begin
                                    ia = {7'd0, b[7-p]};
                                    ib = {7'd0, b[6-p]};
                                    n_list[k] = mk(KIND_RUN, c[13:0], r_row,
                                                   (rem >= 17'd2) ? 8'd2 : 8'd1, ia, ib);
                                    k = k + 3'd1;
                                end else if (p == 0) begin
                                    if (r_depth == DEPTH_4) begin
                                        ia = {4'd0, b[7:4]};
                                        ib = {4'd0, b[3:0]};
                                        n_list[k] = mk(KIND_RUN, c[13:0], r_row,
                                                       (rem >= 17'd2) ? 8'd2 : 8'd1, ia, ib);
                                    end else begin
                                        n_list[k] = mk(KIND_RUN, c[13:0], r_row, 8'd1, b, b);
                                    end
                                    k = k + 3'd1;
                                end
                            end
                        end
                        rbc1 = {1'b0, r_rbc} + 14'd1;
                        n_rbc = rbc1[12:0];
                        if (17'(rbc1) >= per_row) begin
                            n_list[k] = mk(KIND_EOL, '0, r_row, '0, '0, '0);
                            k = k + 3'd1;
                            n_rbc = '0;
                            n_row = r_row + 14'd1;
                            if (n_row >= h) begin
                                n_list[k] = mk(KIND_EOI, '0, n_row, '0, '0, '0);
                                k = k + 3'd1;
                                n_phase = PH_DONE;
                            end
                        end
                    end else begin
                        n_par = ~r_par;
                        case (r_phase)
                            PH_COUNT: begin
                                if (!odd) begin
                                    n_held  = b;
                                    n_phase = (b == 8'd0) ? PH_ESCAPE : PH_VALUE;
                                end
                            end
                            PH_VALUE: begin
                                do_run = 1'b1;
                                n = r_held;
                                ia = four ? {4'd0, b[7:4]} : b;
                                ib = four ? {4'd0, b[3:0]} : b;
                                n_phase = PH_COUNT;
                            end
                            PH_ESCAPE: begin
                                if (b == ESC_EOL) begin
                                    if (r_row < h) begin
                                        n_list[k] = mk(KIND_EOL, '0, r_row, '0, '0, '0);
                                        k = k + 3'd1;
                                    end
                                    n_col = '0;
                                    n_row = (r_row + 14'd1 > h) ? h : r_row + 14'd1;
                                    n_phase = PH_COUNT;
                                end else if (b == ESC_EOI) begin
                                    n_list[k] = mk(KIND_EOI, '0, r_row, '0, '0, '0);
                                    k = k + 3'd1;
                                    n_phase = PH_DONE;
                                end else if (b == ESC_DELTA) begin
                                    n_phase = PH_DX;
                                end else begin
                                    n_abs   = b;
                                    n_phase = PH_ABS;
                                end
                            end
                            PH_DX: begin
                                n_held  = b;
                                n_phase = PH_DY;
                            end
                            PH_DY: begin
                                sum   = {1'b0, r_col} + 15'(r_held);
                                n_col = (sum > 15'(w)) ? w : sum[13:0];
                                sum   = {1'b0, r_row} + 15'(b);
                                n_row = (sum > 15'(h)) ? h : sum[13:0];
                                n_phase = PH_COUNT;
                            end
                            PH_ABS: begin
                                do_run = 1'b1;
                                if (four) begin
                                    n  = (r_abs >= 8'd2) ? 8'd2 : r_abs;
                                    ia = {4'd0, b[7:4]};
                                    ib = {4'd0, b[3:0]};
                                end else begin
                                    n  = 8'd1;
                                    ia = b;
                                    ib = b;
                                end
                                n_abs = (four || r_abs != 8'd0) ? r_abs - n : r_abs;
                                if (!four && r_abs == 8'd0) n_abs = '0;
                                if (n_abs == 8'd0) n_phase = PH_COUNT;
                            end
                            default: begin
                                n_phase = PH_DONE;
                            end
                        endcase
                        if (do_run) begin
                            if (r_col < w && r_row < h && n != 8'd0) begin
                                len14 = w - r_col;
                                if (len14 > 14'(n)) len14 = 14'(n);
                                n_list[k] = mk(KIND_RUN, r_col, r_row, len14[7:0], ia, ib);
                                k = k + 3'd1;
                            end
                            sum   = {1'b0, r_col} + 15'(n);
                            n_col = (sum > 15'(w)) ? w : sum[13:0];
                        end
                    end
                    if (i_final_byte && n_phase != PH_DONE) begin
                        n_list[k] = mk(KIND_EOI, '0, n_row, '0, '0, '0);
                        k = k + 3'd1;
                        n_phase = PH_DONE;
                    end
                    if (k != 3'd0) n_list[k - 3'd1].last = 1'b1;
                end
            end
            default: begin
            end
        endcase
        n_cnt = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= 2'd2;
            r_rle    <= 1'b0;
            r_width  <= 14'd1;
            r_height <= 14'd1;
            r_phase  <= PH_COUNT;
            r_col    <= '0;
            r_row    <= '0;
            r_held   <= '0;
            r_abs    <= '0;
            r_par    <= 1'b0;
            r_rbc    <= '0;
            r_left   <= '0;
            r_ptr    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DEPTH:  r_depth  <= i_cfg_data[1:0];
                    REG_RLE:    r_rle    <= i_cfg_data[0];
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_phase <= n_phase;
                r_col   <= n_col;
                r_row   <= n_row;
                r_held  <= n_held;
                r_abs   <= n_abs;
                r_par   <= n_par;
                r_rbc   <= n_rbc;
                r_left  <= n_cnt;
                r_ptr   <= '0;
            end else if (o_push) begin
                r_left <= r_left - 3'd1;
                r_ptr  <= r_ptr + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_list <= n_list;
        end
    end

endmodule

// ===== design/bmpd_queue.sv =====
module bmpd_queue
    import bmpd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_desc o_desc
);

    t_desc                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wp, r_rp;
    logic [QUEUE_AW:0]    r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_desc  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_desc;
    end

endmodule

// ===== design/bmpd_back.sv =====
module bmpd_back
    import bmpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_desc       i_desc,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [12:0] o_column,
    output logic [12:0] o_row,
    output logic [7:0]  o_run_length,
    output logic [23:0] o_first_color,
    output logic [23:0] o_second_color,
    output logic        o_last
);

    logic [23:0] r_pal [PALETTE_DEPTH];
    logic [23:0] r_rd_a, r_rd_b;
    t_desc       r_s1;
    logic        r_s1_v;
    logic        adv;

    assign adv   = !o_valid || !i_stall;
    assign o_pop = !i_empty && (!r_s1_v || adv);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_desc.pal_wr) r_pal[i_desc.idx_a] <= i_desc.rgb;
            r_rd_a <= r_pal[i_desc.idx_a];
            r_rd_b <= r_pal[i_desc.idx_b];
            r_s1   <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (o_pop) r_s1_v <= !i_desc.pal_wr;
            else if (adv) r_s1_v <= 1'b0;
            if (adv) o_valid <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_v) begin
            o_kind         <= r_s1.kind;
            o_column       <= r_s1.column;
            o_row          <= r_s1.row;
            o_run_length   <= r_s1.run_length;
            o_first_color  <= (r_s1.kind == KIND_RUN) ? r_rd_a : '0;
            o_second_color <= (r_s1.kind == KIND_RUN) ? r_rd_b : '0;
            o_last         <= r_s1.last;
        end
    end

endmodule

// ===== design/bmp_palette_rle_pixel_decoder_core.sv =====
// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------------
// request   | i_valid / o_stall  | i_cmd i_data_byte i_palette_index
//           |                    | i_palette_rgb i_final_byte
// result    | o_valid / i_stall  | o_kind o_column o_row o_run_length
//           |                    | o_first_color o_second_color o_last
// config    | i_cfg_we           | i_cfg_index i_cfg_data
//
// a request is parsed as it is taken into up to six work entries, which leave
// the parser one per cycle, while the queue has room, into a four-entry queue;
// a request is taken every cycle while it yields at most one entry and the queue
// has room, otherwise once the last of its entries is being pushed; results then
// pass through the queue, the palette read register and the output register
// reset is synchronous and clears the parser, queue and output valid; the
// palette keeps whatever was written
// a stalled output holds the back end; the parser keeps going until the queue fills
module bmp_palette_rle_pixel_decoder_core
    import bmpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [13:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_palette_index,
    input  logic [23:0] i_palette_rgb,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [12:0] o_column,
    output logic [12:0] o_row,
    output logic [7:0]  o_run_length,
    output logic [23:0] o_first_color,
    output logic [23:0] o_second_color,
    output logic        o_last
);

    // parser to queue
    logic  push, q_full;
    t_desc push_desc;
    // queue to palette / output stage
    logic  pop, q_empty;
    t_desc pop_desc;

    bmpd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_data_byte    (i_data_byte),
        .i_palette_index(i_palette_index),
        .i_palette_rgb  (i_palette_rgb),
        .i_final_byte   (i_final_byte),
        .o_push         (push),
        .o_desc         (push_desc),
        .i_q_full       (q_full)
    );

    // palette writes travel through the queue so they stay ordered with reads
    bmpd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_desc (push_desc),
        .o_full (q_full),
        .i_pop  (pop),
        .o_empty(q_empty),
        .o_desc (pop_desc)
    );

    bmpd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_desc        (pop_desc),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_column      (o_column),
        .o_row         (o_row),
        .o_run_length  (o_run_length),
        .o_first_color (o_first_color),
        .o_second_color(o_second_color),
        .o_last        (o_last)
    );

endmodule

// ===== tb/sv/bmpd_checker.sv =====
module bmpd_checker
    import bmpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [13:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_req_stall,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_palette_index,
    input  logic [23:0] i_palette_rgb,
    input  logic        i_final_byte,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [1:0]  i_kind,
    input  logic [12:0] i_column,
    input  logic [12:0] i_row,
    input  logic [7:0]  i_run_length,
    input  logic [23:0] i_first_color,
    input  logic [23:0] i_second_color,
    input  logic        i_last,
    output int          o_requests,
    output int          o_open,
    output int          o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        ST_COUNT, ST_VALUE, ST_ESCAPE, ST_DX, ST_DY, ST_ABS, ST_DONE
    } parse_st_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [12:0] column;
        logic [12:0] row;
        logic [7:0]  run_length;
        logic [23:0] color_a;
        logic [23:0] color_b;
        logic        last;
    } segment_t;

    segment_t    segments_due[$];
    logic [23:0] palette_mem [PALETTE_DEPTH];

    logic [1:0]  depth_cfg;
    logic        rle_cfg;
    logic [13:0] width_cfg, height_cfg;

    int unsigned col_pos, row_pos, held_cnt, abs_left, row_bytes;
    logic        parity;
    parse_st_t   phase;

    function automatic int unsigned clamp_dim(logic [13:0] v);
        if (v == 0) return 1;
        return (v > MAX_WIDTH) ? MAX_WIDTH : v;
    endfunction

    function automatic logic [23:0] color_of(int unsigned idx);
        return (idx < PALETTE_DEPTH) ? palette_mem[idx] : 24'd0;
    endfunction

    task automatic push_segment(logic [1:0] kind, int unsigned col, int unsigned row,
                                int unsigned len, logic [23:0] ca, logic [23:0] cb);
        segment_t s;
        s = '{kind, col[12:0], row[12:0], len[7:0], ca, cb, 1'b0};
        segments_due.push_back(s);
    endtask

    task automatic clear_parser();
        col_pos = 0; row_pos = 0; held_cnt = 0; abs_left = 0; row_bytes = 0;
        parity = 1'b0; phase = ST_COUNT;
    endtask

    task automatic end_of_image();
        push_segment(KIND_EOI, 0, row_pos, 0, 24'd0, 24'd0);
        phase = ST_DONE;
    endtask

    // run of n pixels at the current position, clipped at the image edge
    task automatic pixel_run(int unsigned n, logic [23:0] ca, logic [23:0] cb);
        int unsigned w, h, len;
        w = clamp_dim(width_cfg);
        h = clamp_dim(height_cfg);
        if (col_pos < w && row_pos < h && n > 0) begin
            len = (w - col_pos < n) ? w - col_pos : n;
            push_segment(KIND_RUN, col_pos, row_pos, len, ca, (len == 1) ? ca : cb);
        end
        col_pos = (col_pos + n > w) ? w : col_pos + n;
    endtask

    task automatic plain_byte(logic [7:0] b);
        int unsigned w, h, bits, ppb, per_row, c, len, ia, ib;
        w = clamp_dim(width_cfg);
        h = clamp_dim(height_cfg);
        bits = (depth_cfg == DEPTH_1) ? 1 : ((depth_cfg == DEPTH_4) ? 4 : 8);
        ppb = 8 / bits;
        per_row = ((w * bits + 31) / 32) * 4;
        for (int unsigned p = 0; p < ppb; p += 2) begin
            c = row_bytes * ppb + p;
            if (c >= w) break;
            if (bits == 8) begin
                push_segment(KIND_RUN, c, row_pos, 1, color_of(b), color_of(b));
                break;
            end
            if (bits == 4) begin
                ia = b[7:4]; ib = b[3:0];
            end else begin
                ia = b[7 - p]; ib = b[6 - p];
            end
            len = (w - c >= 2) ? 2 : 1;
            push_segment(KIND_RUN, c, row_pos, len, color_of(ia),
                         (len == 2) ? color_of(ib) : color_of(ia));
        end
        row_bytes++;
        if (row_bytes >= per_row) begin
            push_segment(KIND_EOL, 0, row_pos, 0, 24'd0, 24'd0);
            row_bytes = 0;
            row_pos++;
            if (row_pos >= h) end_of_image();
        end
    endtask

    task automatic coded_byte(logic [7:0] b, logic four);
        int unsigned w, h, n;
        logic odd;
        w = clamp_dim(width_cfg);
        h = clamp_dim(height_cfg);
        odd = parity;
        parity = ~parity;
        case (phase)
            ST_COUNT: begin
                // pad byte for word alignment
                if (!odd) begin
                    held_cnt = b;
                    phase = (b == 0) ? ST_ESCAPE : ST_VALUE;
                end
            end
            ST_VALUE: begin
                if (four) pixel_run(held_cnt, color_of(b[7:4]), color_of(b[3:0]));
                else pixel_run(held_cnt, color_of(b), color_of(b));
                phase = ST_COUNT;
            end
            ST_ESCAPE: begin
                if (b == ESC_EOL) begin
                    if (row_pos < h) push_segment(KIND_EOL, 0, row_pos, 0, 24'd0, 24'd0);
                    col_pos = 0;
                    row_pos = (row_pos + 1 > h) ? h : row_pos + 1;
                    phase = ST_COUNT;
                end else if (b == ESC_EOI) begin
                    end_of_image();
                end else if (b == ESC_DELTA) begin
                    phase = ST_DX;
                end else begin
                    abs_left = b;
                    phase = ST_ABS;
                end
            end
            ST_DX: begin
                held_cnt = b;
                phase = ST_DY;
            end
            ST_DY: begin
                col_pos = (col_pos + held_cnt > w) ? w : col_pos + held_cnt;
                row_pos = (row_pos + b > h) ? h : row_pos + b;
                phase = ST_COUNT;
            end
            ST_ABS: begin
                if (four) begin
                    n = (abs_left >= 2) ? 2 : abs_left;
                    pixel_run(n, color_of(b[7:4]), color_of(b[3:0]));
                    abs_left -= n;
                end else begin
                    pixel_run(1, color_of(b), color_of(b));
                    if (abs_left != 0) abs_left--;
                end
                if (abs_left == 0) phase = ST_COUNT;
            end
            default: phase = ST_DONE;
        endcase
    endtask

    task automatic predict_request();
        int first_new;
        first_new = segments_due.size();
        if (i_cmd == CMD_PALETTE) begin
            if (i_palette_index < PALETTE_DEPTH) palette_mem[i_palette_index] = i_palette_rgb;
        end else if (i_cmd == CMD_START) begin
            clear_parser();
        end else if (i_cmd == CMD_DATA && phase != ST_DONE) begin
            if (rle_cfg && depth_cfg != DEPTH_1) coded_byte(i_data_byte, depth_cfg == DEPTH_4);
            else plain_byte(i_data_byte);
            if (i_final_byte && phase != ST_DONE) end_of_image();
            if (segments_due.size() > first_new) segments_due[$].last = 1'b1;
        end
    endtask

    task automatic report_mismatch(string what, longint want, longint got);
        $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
        o_errors++;
    endtask

    task automatic check_segment();
        segment_t s;
        if (segments_due.size() == 0) begin
            report_mismatch("unexpected result, kind", 0, i_kind);
            return;
        end
        s = segments_due.pop_front();
        if (i_kind != s.kind) report_mismatch("kind", s.kind, i_kind);
        if (i_column != s.column) report_mismatch("column", s.column, i_column);
        if (i_row != s.row) report_mismatch("row", s.row, i_row);
        if (i_run_length != s.run_length) report_mismatch("run_length", s.run_length, i_run_length);
        if (i_first_color != s.color_a) report_mismatch("first_color", s.color_a, i_first_color);
        if (i_second_color != s.color_b) report_mismatch("second_color", s.color_b, i_second_color);
        if (i_last != s.last) report_mismatch("last", s.last, i_last);
    endtask

    initial begin
        o_requests = 0;
        o_open = 0;
        o_errors = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            depth_cfg = 2'd2; rle_cfg = 1'b0; width_cfg = 14'd1; height_cfg = 14'd1;
            clear_parser();
            segments_due.delete();
        end else begin
            if (i_res_valid && !i_res_stall) check_segment();
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DEPTH:  depth_cfg = i_cfg_data[1:0];
                    REG_RLE:    rle_cfg = i_cfg_data[0];
                    REG_WIDTH:  width_cfg = i_cfg_data;
                    REG_HEIGHT: height_cfg = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_valid && !i_req_stall) begin
                predict_request();
                o_requests++;
            end
        end
        o_open = segments_due.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import bmpd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 24;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [13:0] i_cfg_data;
    logic        i_valid, o_stall;
    logic [1:0]  i_cmd;
    logic [7:0]  i_data_byte, i_palette_index;
    logic [23:0] i_palette_rgb;
    logic        i_final_byte;
    logic        o_valid, i_stall;
    logic [1:0]  o_kind;
    logic [12:0] o_column, o_row;
    logic [7:0]  o_run_length;
    logic [23:0] o_first_color, o_second_color;
    logic        o_last;

    int n_requests, n_open, n_errors;
    int n_sent, n_bytes, cycles, rx_wait;
    bit no_gaps;    // stretches without idling on either side

    bmp_palette_rle_pixel_decoder_core u_top (.*);

    bmpd_checker u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .i_req_stall(o_stall), .i_cmd, .i_data_byte, .i_palette_index,
        .i_palette_rgb, .i_final_byte,
        .i_res_valid(o_valid), .i_res_stall(i_stall), .i_kind(o_kind),
        .i_column(o_column), .i_row(o_row), .i_run_length(o_run_length),
        .i_first_color(o_first_color), .i_second_color(o_second_color), .i_last(o_last),
        .o_requests(n_requests), .o_open(n_open), .o_errors(n_errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stall before each result
    always @(negedge i_clk) begin
        if (rx_wait > 0) begin
            i_stall = 1'b1;
            rx_wait--;
        end else begin
            i_stall = 1'b0;
            if (o_valid) rx_wait = no_gaps ? 0 : $urandom_range(0, 16);
        end
    end

    // pixel byte; in 8 bit mode only indices 0x00-0x0F and 0xF0-0xFF are used
    function automatic logic [7:0] pix(bit eight);
        logic [3:0] hi;
        hi = ($urandom_range(0, 1) != 0) ? 4'hF : 4'h0;
        return eight ? {hi, 4'($urandom)} : 8'($urandom);
    endfunction

    // one request; valid stays high when the next follows without a gap
    task automatic send(logic [1:0] cmd, logic [7:0] b, logic [7:0] idx,
                        logic [23:0] rgb, logic fin);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd = cmd; i_data_byte = b; i_palette_index = idx;
        i_palette_rgb = rgb; i_final_byte = fin;
        i_valid = 1'b1;
        n_sent++;
        wait (n_requests == n_sent);
        @(negedge i_clk);
    endtask

    task automatic data_byte(logic [7:0] b, logic fin = 1'b0);
        send(CMD_DATA, b, 8'($urandom), 24'($urandom), fin);
        n_bytes++;
    endtask

    task automatic pal_write(logic [7:0] idx, logic [23:0] rgb);
        send(CMD_PALETTE, 8'($urandom), idx, rgb, 1'b0);
    endtask

    // registers change only with the block drained
    task automatic drain();
        i_valid = 1'b0;
        wait (n_open == 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [13:0] val);
        i_cfg_we = 1'b1; i_cfg_index = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic new_image(logic [1:0] depth, logic rle, logic [13:0] w, logic [13:0] h);
        drain();
        set_reg(REG_DEPTH, 14'(depth));
        set_reg(REG_RLE, 14'(rle));
        set_reg(REG_WIDTH, w);
        set_reg(REG_HEIGHT, h);
        send(CMD_START, 8'($urandom), 8'($urandom), 24'($urandom), 1'b0);
    endtask

    // uncompressed rows, sometimes cut short by a final byte, sometimes overrun
    task automatic plain_image(logic [1:0] depth, int unsigned w, int unsigned h);
        int unsigned bits, total, stop_at;
        bits = (depth == DEPTH_1) ? 1 : ((depth == DEPTH_4) ? 4 : 8);
        total = ((w * bits + 31) / 32) * 4 * h;
        stop_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, total) : total + 2;
        for (int unsigned i = 1; i <= total + 1 && i <= stop_at; i++)
            data_byte(pix(bits == 8), i == stop_at);
    endtask

    // well-formed coded stream with random content and some noise
    task automatic coded_image(bit four, int ops);
        int unsigned n, nb;
        for (int k = 0; k < ops; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    data_byte(($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(1, 15)));
                    data_byte(pix(!four));
                end
                4, 5: begin
                    n = $urandom_range(3, 12);
                    nb = four ? (n + 1) / 2 : n;
                    data_byte(8'd0);
                    data_byte(8'(n));
                    repeat (nb) data_byte(pix(!four));
                    if (nb % 2) data_byte(pix(!four));
                end
                6: begin
                    data_byte(8'd0);
                    data_byte(ESC_EOL);
                end
                7: begin
                    data_byte(8'd0);
                    data_byte(ESC_DELTA);
                    data_byte(8'($urandom_range(0, 9)));
                    data_byte(8'($urandom_range(0, 1)));
                end
                default: data_byte(pix(!four));
            endcase
        end
        if ($urandom_range(0, 1)) begin
            data_byte(8'd0);
            data_byte(ESC_EOI);
        end else begin
            data_byte(8'($urandom_range(1, 9)), 1'b1);
        end
    endtask

    initial begin
        logic [1:0]  depth;
        logic        rle;
        logic [13:0] w, h;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = REG_DEPTH; i_cfg_data = '0;
        i_valid = 1'b0; i_cmd = CMD_DATA; i_data_byte = '0; i_palette_index = '0;
        i_palette_rgb = '0; i_final_byte = 1'b0; i_stall = 1'b0;
        n_sent = 0; n_bytes = 0; cycles = 0; rx_wait = 0; no_gaps = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // low and high sixteen entries; every pixel byte sent indexes only these
        for (int i = 0; i < 16; i++) begin
            pal_write(8'(i), 24'($urandom));
            pal_write(8'(240 + i), 24'($urandom));
        end
        pal_write(8'd0, 24'h000000);
        pal_write(8'd255, 24'hFFFFFF);

        // directed: 8 bit plain, extremes
        new_image(2'd2, 1'b0, 14'd3, 14'd2);
        data_byte(8'h00); data_byte(8'hFF); data_byte(8'hF5); data_byte(8'h0A);
        data_byte(8'hFF); data_byte(8'h00); data_byte(8'h01); data_byte(8'hF0);
        data_byte(8'h33);   // after end of image, ignored
        // 1 bit plain, odd width clips the last pair
        new_image(DEPTH_1, 1'b0, 14'd9, 14'd1);
        data_byte(8'hA5); data_byte(8'h80); data_byte(8'h00); data_byte(8'h00);
        // coded 8 bit at the largest size: run, absolute with pad, delta, eol, eoi
        new_image(2'd2, 1'b1, 14'd8192, 14'd8192);
        data_byte(8'd255); data_byte(8'hFF);
        data_byte(8'd0); data_byte(8'd3); data_byte(8'h01); data_byte(8'hF2);
        data_byte(8'h03); data_byte(8'h00);
        data_byte(8'd0); data_byte(ESC_DELTA); data_byte(8'd255); data_byte(8'd255);
        data_byte(8'd0); data_byte(ESC_EOL);
        data_byte(8'd0); data_byte(ESC_EOI);
        // coded 4 bit, width one clips runs to one pixel
        new_image(DEPTH_4, 1'b1, 14'd1, 14'd1);
        data_byte(8'd7); data_byte(8'h1E);
        data_byte(8'd0); data_byte(ESC_EOL);
        data_byte(8'd3); data_byte(8'h45, 1'b1);

        // random images
        while (n_bytes < 170) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            depth = 2'($urandom_range(0, 2));
            rle = 1'($urandom_range(0, 1));
            w = 14'($urandom_range(1, 40));
            h = 14'($urandom_range(1, 4));
            if (rle && $urandom_range(0, 5) == 0) w = 14'd8192;
            if (rle && $urandom_range(0, 5) == 0) h = 14'd8192;
            new_image(depth, rle, w, h);
            if ($urandom_range(0, 3) == 0) pal_write(8'($urandom), 24'($urandom));
            if (rle && depth != DEPTH_1) coded_image(depth == DEPTH_4, $urandom_range(3, 12));
            else plain_image(depth, w, h);
        end

        drain();
        if (n_errors == 0 && n_open == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
